// ----- sv/table_file_decrypt_parser_top_defines.svh -----
// ----------------------------------------------------------------------------
// Table file decrypt parser: assertion macros
// Shared property forms for the concurrent checks of the parser.
// ----------------------------------------------------------------------------
`ifndef TABLE_FILE_DECRYPT_PARSER_TOP_DEFINES_SVH
`define TABLE_FILE_DECRYPT_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TFDP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TFDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tfdp_pkg.sv -----
// ----------------------------------------------------------------------------
// Table file decrypt parser package
// Payload types, register indexes, result and error codes, type helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfdp_pkg;

    // Geometry
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 17;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_SEED       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_MULTIPLIER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ADDEND     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECRYPT_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LIMIT      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_LIMIT   = 3'd5;

    // Configuration reset values
    localparam logic [15:0] KEY_SEED_RST       = 16'h0816;
    localparam logic [15:0] KEY_MULTIPLIER_RST = 16'h6081;
    localparam logic [15:0] KEY_ADDEND_RST     = 16'h1608;
    localparam logic        DECRYPT_ENABLE_RST = 1'b1;
    localparam logic [16:0] ROW_LIMIT_RST      = 17'd100000;
    localparam logic [15:0] STRING_LIMIT_RST   = 16'd50000;

    // Result kinds
    localparam logic [2:0] KIND_FIELD     = 3'd0;
    localparam logic [2:0] KIND_STR_BYTE  = 3'd1;
    localparam logic [2:0] KIND_STR_EMPTY = 3'd2;
    localparam logic [2:0] KIND_DONE      = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_COL_COUNT = 3'd1;
    localparam logic [2:0] ERR_TYPE      = 3'd2;
    localparam logic [2:0] ERR_ROW_COUNT = 3'd3;
    localparam logic [2:0] ERR_STR_LEN   = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    // Column type codes
    localparam logic [3:0] TYPE_NONE   = 4'd0;
    localparam logic [3:0] TYPE_CHAR   = 4'd1;
    localparam logic [3:0] TYPE_BYTE   = 4'd2;
    localparam logic [3:0] TYPE_SHORT  = 4'd3;
    localparam logic [3:0] TYPE_WORD   = 4'd4;
    localparam logic [3:0] TYPE_STRING = 4'd7;
    localparam logic [3:0] TYPE_DOUBLE = 4'd9;
    localparam logic [3:0] TYPE_FIRST  = 4'd1;
    localparam logic [3:0] TYPE_LAST   = 4'd9;

    // Size in bytes of a header word and of each field type
    localparam logic [3:0] WORD_BYTES = 4'd4;

    function automatic logic [3:0] type_size(input logic [3:0] code);
        logic [3:0] size;
        case (code)
            TYPE_CHAR, TYPE_BYTE:   size = 4'd1;
            TYPE_SHORT, TYPE_WORD:  size = 4'd2;
            TYPE_DOUBLE:            size = 4'd8;
            default:                size = 4'd4;
        endcase
        return size;
    endfunction

    // One input byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
        logic       file_end;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [16:0] row_index;
        logic [9:0]  column_index;
        logic [3:0]  column_type;
        logic [63:0] field_value;
        logic        last_of_string;
        logic [2:0]  error_code;
    } t_out_item;

endpackage

// ----- sv/table_file_decrypt_parser_top.sv -----
// A byte's result is registered in the output register, or in the skid while it is held.
// Throughput: one byte per cycle while the skid register is empty (else o_in_stall is high);
// the key update multiply and the parse step are combinational; the column type memory read
// is issued ahead for the next column. Up to two results are buffered (output plus skid).
// Reset: registers to defaults, key to the seed, parser waits for a column count;
// the column type memory is not cleared (every type is written before it is read).
// ----------------------------------------------------------------------------
// Table file decrypt parser, top level
// Decrypts a byte stream with a running key and parses the table layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "table_file_decrypt_parser_top_defines.svh"

module table_file_decrypt_parser_top #(
    parameter int MAX_COLUMNS = tfdp_pkg::MAX_COLUMNS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input byte channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tfdp_pkg::t_in_item                 i_in_data,
    // Result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tfdp_pkg::t_out_item                o_out_data,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [tfdp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [tfdp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    typedef enum logic [5:0] {
        PH_COLS  = 6'b000001,
        PH_TYPES = 6'b000010,
        PH_ROWS  = 6'b000100,
        PH_FIELD = 6'b001000,
        PH_STR   = 6'b010000,
        PH_HALT  = 6'b100000
    } t_phase;

    // Configuration registers
    logic [15:0] r_seed;
    logic [15:0] r_mult;
    logic [15:0] r_add;
    logic        r_dec_en;
    logic [16:0] r_row_limit;
    logic [15:0] r_str_limit;

    // Parser state
    logic [15:0]      r_key,      n_key;
    t_phase           r_phase,    n_phase;
    logic [2:0]       r_bif,      n_bif;
    logic [63:0]      r_acc,      n_acc;
    logic [CNT_W-1:0] r_ncols,    n_ncols;
    logic [COL_W-1:0] r_col,      n_col;
    logic [16:0]      r_row,      n_row;
    logic [16:0]      r_nrows,    n_nrows;
    logic [15:0]      r_str_left, n_str_left;
    logic [3:0]       r_cur_type, n_cur_type;

    // Column type memory
    logic [3:0]       r_type_mem [MAX_COLUMNS];
    logic [3:0]       r_rd_data;
    logic [COL_W-1:0] rd_addr;
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    logic [3:0]       mem_wdata;

    // Output register and skid
    tfdp_pkg::t_out_item r_out, r_skid;
    logic                r_out_valid, r_skid_valid;

    // Step signals
    logic                accept;
    logic                out_take;
    logic                out_free;
    t_phase              e_phase;
    logic [15:0]         e_key;
    logic [2:0]          e_bif;
    logic [63:0]         e_acc;
    logic [CNT_W-1:0]    e_ncols;
    logic [COL_W-1:0]    e_col;
    logic [16:0]         e_row;
    logic [16:0]         e_nrows;
    logic [15:0]         e_str_left;
    logic [7:0]          plain;
    logic [15:0]         key_sum;
    logic [31:0]         key_prod;
    logic [15:0]         key_next;
    logic [3:0]          g_size;
    logic [63:0]         g_val;
    logic                g_done;
    logic [31:0]         g_word;
    logic [CNT_W-1:0]    col_inc;
    logic                adv_wrap;
    logic [17:0]         row_inc;
    logic                adv_done;
    logic [31:0]         e_col_wide;
    logic [31:0]         n_col_wide;
    logic [15:0]         str_dec;
    logic [CNT_W-1:0]    nx_inc;
    logic [CNT_W-1:0]    col_cnt;
    logic                res_v;
    tfdp_pkg::t_out_item res;

    assign accept      = i_in_valid & ~o_in_stall;
    assign out_take    = r_out_valid & ~i_out_stall;
    assign out_free    = ~r_out_valid | out_take;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign col_cnt     = CNT_W'(r_col);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= tfdp_pkg::KEY_SEED_RST;
            r_mult      <= tfdp_pkg::KEY_MULTIPLIER_RST;
            r_add       <= tfdp_pkg::KEY_ADDEND_RST;
            r_dec_en    <= tfdp_pkg::DECRYPT_ENABLE_RST;
            r_row_limit <= tfdp_pkg::ROW_LIMIT_RST;
            r_str_limit <= tfdp_pkg::STRING_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfdp_pkg::CFG_KEY_SEED:       r_seed      <= i_cfg_data[15:0];
                tfdp_pkg::CFG_KEY_MULTIPLIER: r_mult      <= i_cfg_data[15:0];
                tfdp_pkg::CFG_KEY_ADDEND:     r_add       <= i_cfg_data[15:0];
                tfdp_pkg::CFG_DECRYPT_ENABLE: r_dec_en    <= i_cfg_data[0];
                tfdp_pkg::CFG_ROW_LIMIT:      r_row_limit <= i_cfg_data[16:0];
                tfdp_pkg::CFG_STRING_LIMIT:   r_str_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Restart view of the state: file_start reloads the key and the parser
    always_comb begin
        if (i_in_data.file_start) begin
            e_key      = r_seed;
            e_phase    = PH_COLS;
            e_bif      = '0;
            e_acc      = '0;
            e_ncols    = '0;
            e_col      = '0;
            e_row      = '0;
            e_nrows    = '0;
            e_str_left = '0;
        end else begin
            e_key      = r_key;
            e_phase    = r_phase;
            e_bif      = r_bif;
            e_acc      = r_acc;
            e_ncols    = r_ncols;
            e_col      = r_col;
            e_row      = r_row;
            e_nrows    = r_nrows;
            e_str_left = r_str_left;
        end
    end

    // Decrypt and key update
    always_comb begin
        plain    = r_dec_en ? (i_in_data.in_byte ^ e_key[15:8]) : i_in_data.in_byte;
        key_sum  = {8'h00, i_in_data.in_byte} + e_key;
        key_prod = key_sum * r_mult;
        key_next = key_prod[15:0] + r_add;
    end

    // Byte gather into the field accumulator, and field advance
    always_comb begin
        g_size = (e_phase == PH_FIELD) ? tfdp_pkg::type_size(r_cur_type) : tfdp_pkg::WORD_BYTES;
        for (int k = 0; k < 8; k++) begin
            g_val[k*8 +: 8] = (e_bif == 3'(k)) ? plain : e_acc[k*8 +: 8];
        end
        g_done     = ({1'b0, e_bif} + 4'd1) >= g_size;
        g_word     = g_val[31:0];
        col_inc    = CNT_W'(e_col) + CNT_W'(1);
        adv_wrap   = col_inc >= e_ncols;
        row_inc    = {1'b0, e_row} + 18'd1;
        adv_done   = adv_wrap && (row_inc >= {1'b0, e_nrows});
        e_col_wide = 32'(e_col);
        str_dec    = (e_str_left != '0) ? (e_str_left - 16'd1) : e_str_left;
    end

    // Parse step
    always_comb begin
        n_key      = r_key;
        n_phase    = r_phase;
        n_bif      = r_bif;
        n_acc      = r_acc;
        n_ncols    = r_ncols;
        n_col      = r_col;
        n_row      = r_row;
        n_nrows    = r_nrows;
        n_str_left = r_str_left;
        n_cur_type = r_cur_type;
        mem_we     = 1'b0;
        mem_waddr  = e_col;
        mem_wdata  = tfdp_pkg::TYPE_NONE;
        res_v      = 1'b0;
        res        = '0;
        n_col_wide = '0;

        if (accept) begin
            n_key      = r_dec_en ? key_next : e_key;
            n_phase    = e_phase;
            n_bif      = e_bif;
            n_acc      = e_acc;
            n_ncols    = e_ncols;
            n_col      = e_col;
            n_row      = e_row;
            n_nrows    = e_nrows;
            n_str_left = e_str_left;

            case (e_phase)
                PH_COLS: begin
                    n_bif = g_done ? 3'd0 : (e_bif + 3'd1);
                    n_acc = g_done ? 64'd0 : g_val;
                    if (g_done) begin
                        if (g_word[31] || (g_word == 32'd0) || (g_word > 32'(MAX_COLUMNS))) begin
                            res_v                = 1'b1;
                            res.result_kind      = tfdp_pkg::KIND_ERROR;
                            res.error_code       = tfdp_pkg::ERR_COL_COUNT;
                            res.field_value      = {32'd0, g_word};
                            n_phase              = PH_HALT;
                        end else begin
                            n_ncols = g_word[CNT_W-1:0];
                            n_col   = '0;
                            n_phase = PH_TYPES;
                        end
                    end
                end
                PH_TYPES: begin
                    n_bif = g_done ? 3'd0 : (e_bif + 3'd1);
                    n_acc = g_done ? 64'd0 : g_val;
                    if (g_done) begin
                        // Store the code; out-of-range codes become no type
                        mem_we    = 1'b1;
                        mem_wdata = ((g_word >= 32'(tfdp_pkg::TYPE_FIRST)) &&
                                     (g_word <= 32'(tfdp_pkg::TYPE_LAST)))
                                    ? g_word[3:0] : tfdp_pkg::TYPE_NONE;
                        if (adv_wrap) begin
                            n_col   = '0;
                            n_phase = PH_ROWS;
                        end else begin
                            n_col = col_inc[COL_W-1:0];
                        end
                    end
                end
                PH_ROWS: begin
                    n_bif = g_done ? 3'd0 : (e_bif + 3'd1);
                    n_acc = g_done ? 64'd0 : g_val;
                    if (g_done) begin
                        if (g_word[31] || (g_word > {15'd0, r_row_limit})) begin
                            res_v           = 1'b1;
                            res.result_kind = tfdp_pkg::KIND_ERROR;
                            res.error_code  = tfdp_pkg::ERR_ROW_COUNT;
                            res.field_value = {32'd0, g_word};
                            n_phase         = PH_HALT;
                        end else begin
                            n_nrows = g_word[16:0];
                            n_row   = '0;
                            n_col   = '0;
                            if (g_word == 32'd0) begin
                                res_v           = 1'b1;
                                res.result_kind = tfdp_pkg::KIND_DONE;
                                n_phase         = PH_HALT;
                            end else begin
                                // Memory output holds column zero's type here
                                n_cur_type = r_rd_data;
                                n_phase    = PH_FIELD;
                            end
                        end
                    end
                end
                PH_FIELD: begin
                    res.row_index    = e_row;
                    res.column_index = e_col_wide[9:0];
                    if (r_cur_type == tfdp_pkg::TYPE_NONE) begin
                        res_v           = 1'b1;
                        res.result_kind = tfdp_pkg::KIND_ERROR;
                        res.error_code  = tfdp_pkg::ERR_TYPE;
                        n_phase         = PH_HALT;
                    end else begin
                        res.column_type = r_cur_type;
                        n_bif = g_done ? 3'd0 : (e_bif + 3'd1);
                        n_acc = g_done ? 64'd0 : g_val;
                        if (g_done) begin
                            if (r_cur_type == tfdp_pkg::TYPE_STRING) begin
                                if (g_word[31] || (g_word > {16'd0, r_str_limit})) begin
                                    res_v           = 1'b1;
                                    res.result_kind = tfdp_pkg::KIND_ERROR;
                                    res.error_code  = tfdp_pkg::ERR_STR_LEN;
                                    res.field_value = {32'd0, g_word};
                                    n_phase         = PH_HALT;
                                end else if (g_word == 32'd0) begin
                                    res_v           = 1'b1;
                                    res.result_kind = tfdp_pkg::KIND_STR_EMPTY;
                                end else begin
                                    n_str_left = g_word[15:0];
                                    n_phase    = PH_STR;
                                end
                            end else begin
                                res_v           = 1'b1;
                                res.result_kind = tfdp_pkg::KIND_FIELD;
                                res.field_value = g_val;
                            end
                        end
                    end
                end
                PH_STR: begin
                    res_v                      = 1'b1;
                    res.result_kind            = tfdp_pkg::KIND_STR_BYTE;
                    res.row_index              = e_row;
                    res.column_index           = e_col_wide[9:0];
                    res.column_type            = tfdp_pkg::TYPE_STRING;
                    res.field_value            = {56'd0, plain};
                    n_str_left                 = str_dec;
                    if (str_dec == '0) begin
                        res.last_of_string = 1'b1;
                        n_phase            = PH_FIELD;
                    end
                end
                default: ;
            endcase

            // Advance to the next field once a field result is complete
            if (res_v && ((res.result_kind == tfdp_pkg::KIND_FIELD) ||
                          (res.result_kind == tfdp_pkg::KIND_STR_EMPTY) ||
                          res.last_of_string)) begin
                if (!adv_wrap) begin
                    n_col      = col_inc[COL_W-1:0];
                    n_cur_type = r_rd_data;
                end else begin
                    n_col = '0;
                    n_row = row_inc[16:0];
                    if (adv_done) begin
                        res.result_kind = tfdp_pkg::KIND_DONE;
                        n_phase         = PH_HALT;
                    end else begin
                        n_cur_type = r_rd_data;
                    end
                end
            end

            // Final byte before the parse finished
            n_col_wide = 32'(n_col);
            if (i_in_data.file_end && (n_phase != PH_HALT)) begin
                res_v              = 1'b1;
                res.result_kind    = tfdp_pkg::KIND_ERROR;
                res.error_code     = tfdp_pkg::ERR_TRUNCATED;
                res.row_index      = n_row;
                res.column_index   = n_col_wide[9:0];
                res.column_type    = tfdp_pkg::TYPE_NONE;
                res.field_value    = '0;
                res.last_of_string = 1'b0;
                n_phase            = PH_HALT;
            end
        end
    end

    // Prefetch the type of the column after the next-state column
    always_comb begin
        nx_inc = CNT_W'(n_col) + CNT_W'(1);
        if (((n_phase == PH_FIELD) || (n_phase == PH_STR)) && (nx_inc < n_ncols)) begin
            rd_addr = nx_inc[COL_W-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    // Column type memory: writes only while types are read in, reads matter only
    // once rows start (at least a row count later), so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_type_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_type_mem[rd_addr];
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= tfdp_pkg::KEY_SEED_RST;
            r_phase    <= PH_COLS;
            r_bif      <= '0;
            r_acc      <= '0;
            r_ncols    <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_nrows    <= '0;
            r_str_left <= '0;
        end else begin
            r_key      <= n_key;
            r_phase    <= n_phase;
            r_bif      <= n_bif;
            r_acc      <= n_acc;
            r_ncols    <= n_ncols;
            r_col      <= n_col;
            r_row      <= n_row;
            r_nrows    <= n_nrows;
            r_str_left <= n_str_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_type <= n_cur_type;
    end

    // Output register with skid: drain skid first, else load a new result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (accept && res_v) begin
            if (out_free) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Checks
    `TFDP_ASSERT_SAME(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")
    `TFDP_ASSERT_SAME(a_str_left_nonzero, i_clk, i_rst_n, r_phase == PH_STR, r_str_left != '0, "string phase with no bytes left")
    `TFDP_ASSERT_SAME(a_col_in_range, i_clk, i_rst_n, (r_phase == PH_FIELD) || (r_phase == PH_STR), col_cnt < r_ncols, "column beyond column count")
    `TFDP_ASSERT_NEXT(a_key_hold, i_clk, i_rst_n, i_rst_n && accept && !r_dec_en && !i_in_data.file_start, r_key == $past(r_key), "key changed with decrypt off")

endmodule
